@@ rtl/core/isbnn_pkg.sv @@
// ----------------------------------------------------------------------------
// isbnn_pkg
// Shared types, codes and small arithmetic helpers of the ISBN normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package isbnn_pkg;

	// Depth of the token queue between the byte classifier and the checker.
	localparam int QUEUE_DEPTH = 4;

	// Result status codes.
	localparam logic [1:0] ST_ISBN13    = 2'd0;
	localparam logic [1:0] ST_ISBN10    = 2'd1;
	localparam logic [1:0] ST_BAD_COUNT = 2'd2;
	localparam logic [1:0] ST_BAD_CHECK = 2'd3;

	// Symbol value used for the X check character.
	localparam logic [3:0] X_VALUE      = 4'd10;
	localparam int         STORE_DEPTH  = 13;
	localparam logic [3:0] COUNT_MAX    = 4'd14;

	// One classified byte: an optional replayed digit one, an optional symbol
	// and the end-of-string mark.
	typedef struct packed {
		logic       rep_one;
		logic       sym_valid;
		logic [3:0] sym;
		logic       last;
	} tok_t;

	// Running checker state. t11/s11 are the ISBN-10 prefix sum and sum of
	// prefix sums mod 11, s10 the ISBN-13 weighted sum mod 10, c10 the
	// ISBN-13 sum of a 978-prefixed ISBN-10 mod 10.
	typedef struct packed {
		logic [3:0] cnt;
		logic [3:0] t11;
		logic [3:0] s11;
		logic [3:0] s10;
		logic [3:0] c10;
		logic       x_early;
		logic       x_any;
	} acc_t;

	// 9*1 + 7*3 + 8*1 = 38, kept mod 10.
	localparam acc_t ACC_CLEAR = '{
		cnt: 4'd0, t11: 4'd0, s11: 4'd0, s10: 4'd0, c10: 4'd8,
		x_early: 1'b0, x_any: 1'b0
	};

	// Reduce a value below 22 mod 11.
	function automatic logic [3:0] red11(input logic [4:0] x);
		logic [4:0] r;
		begin
			r = (x >= 5'd11) ? (x - 5'd11) : x;
			red11 = r[3:0];
		end
	endfunction

	// Reduce a value below 40 mod 10.
	function automatic logic [3:0] red10(input logic [5:0] x);
		logic [5:0] r;
		begin
			if (x >= 6'd30) begin
				r = x - 6'd30;
			end else if (x >= 6'd20) begin
				r = x - 6'd20;
			end else if (x >= 6'd10) begin
				r = x - 6'd10;
			end else begin
				r = x;
			end
			red10 = r[3:0];
		end
	endfunction

	// Check digit that brings a sum mod 10 to zero.
	function automatic logic [3:0] check10(input logic [3:0] s);
		begin
			check10 = (s == 4'd0) ? 4'd0 : (4'd10 - s);
		end
	endfunction

	// Fold one symbol into the running checker state.
	function automatic acc_t add_sym(input acc_t a, input logic [3:0] v);
		acc_t       r;
		logic [3:0] t;
		logic [3:0] v10;
		logic [5:0] w13;
		logic [5:0] wc;
		begin
			r   = a;
			v10 = (v == X_VALUE) ? 4'd0 : v;
			if (a.cnt < 4'd13 && v == X_VALUE) begin
				if (a.cnt < 4'd9) begin
					r.x_early = 1'b1;
				end
				r.x_any = 1'b1;
			end
			if (a.cnt < 4'd10) begin
				t     = red11({1'b0, a.t11} + {1'b0, v});
				r.t11 = t;
				r.s11 = red11({1'b0, a.s11} + {1'b0, t});
			end
			if (a.cnt < 4'd12 && v < 4'd10) begin
				w13   = a.cnt[0] ? ({2'b00, v} + {1'b0, v, 1'b0}) : {2'b00, v};
				r.s10 = red10({2'b00, a.s10} + w13);
			end
			if (a.cnt < 4'd9) begin
				wc    = a.cnt[0] ? {2'b00, v10} : ({2'b00, v10} + {1'b0, v10, 1'b0});
				r.c10 = red10({2'b00, a.c10} + wc);
			end
			if (a.cnt < COUNT_MAX) begin
				r.cnt = a.cnt + 4'd1;
			end
			add_sym = r;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/isbnn_front.sv @@
// ----------------------------------------------------------------------------
// isbnn_front
// Byte classifier: trims blanks, strips the ISBN prefix and turns each byte
// into a token for the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module isbnn_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            byte_valid,
	output logic                 byte_stall,
	input  wire logic [7:0]      char_byte,
	input  wire logic            is_last,
	output logic                 tok_push,
	output isbnn_pkg::tok_t      tok,
	input  wire logic            queue_full
);

	localparam logic [3:0] PH_TRIM    = 4'd0;
	localparam logic [3:0] PH_I       = 4'd1;
	localparam logic [3:0] PH_S       = 4'd2;
	localparam logic [3:0] PH_B       = 4'd3;
	localparam logic [3:0] PH_AISBN   = 4'd4;
	localparam logic [3:0] PH_DASH    = 4'd5;
	localparam logic [3:0] PH_DASH1   = 4'd6;
	localparam logic [3:0] PH_ANUM    = 4'd7;
	localparam logic [3:0] PH_POST    = 4'd8;
	localparam logic [3:0] PH_COLLECT = 4'd9;
	localparam logic [3:0] PH_STOP    = 4'd10;

	logic [3:0] phase_q;
	logic [3:0] phase_n;
	logic [3:0] coll_phase;
	logic [7:0] lc;
	logic       is_digit;
	logic       is_x;
	logic       is_blank;
	logic       is_colon;
	logic       is_dash;
	logic       is_skip;
	logic       do_collect;
	logic       rep_one;
	logic       accept;

	assign byte_stall = queue_full;
	assign accept     = byte_valid && !queue_full;

	assign lc       = (char_byte >= 8'h41 && char_byte <= 8'h5A) ? (char_byte + 8'h20) : char_byte;
	assign is_digit = (char_byte >= 8'h30 && char_byte <= 8'h39);
	assign is_x     = (char_byte == 8'h78) || (char_byte == 8'h58);
	assign is_blank = (char_byte == 8'h20) || (char_byte == 8'h09);
	assign is_colon = (char_byte == 8'h3A);
	assign is_dash  = (char_byte == 8'h2D);
	assign is_skip  = is_dash || (char_byte == 8'h20);

	assign coll_phase = (is_digit || is_x || is_skip) ? PH_COLLECT : PH_STOP;

	always_comb begin
		phase_n    = phase_q;
		do_collect = 1'b0;
		rep_one    = 1'b0;
		unique case (phase_q)
			PH_TRIM: begin
				if (!is_blank) begin
					if (lc == 8'h69) begin
						phase_n = PH_I;
					end else begin
						do_collect = 1'b1;
					end
				end
			end
			PH_I:     phase_n = (lc == 8'h73) ? PH_S : PH_STOP;
			PH_S:     phase_n = (lc == 8'h62) ? PH_B : PH_STOP;
			PH_B:     phase_n = (lc == 8'h6E) ? PH_AISBN : PH_STOP;
			PH_AISBN: begin
				if (is_dash) begin
					phase_n = PH_DASH;
				end else if (is_colon || is_blank) begin
					phase_n = PH_POST;
				end else begin
					do_collect = 1'b1;
				end
			end
			PH_DASH: begin
				if (char_byte == 8'h31) begin
					phase_n = PH_DASH1;
				end else begin
					do_collect = 1'b1;
				end
			end
			PH_DASH1: begin
				if (char_byte == 8'h33 || char_byte == 8'h30) begin
					phase_n = PH_ANUM;
				end else begin
					rep_one    = 1'b1;
					do_collect = 1'b1;
				end
			end
			PH_ANUM: begin
				if (is_colon || is_blank) begin
					phase_n = PH_POST;
				end else begin
					do_collect = 1'b1;
				end
			end
			PH_POST: begin
				if (!is_blank) begin
					do_collect = 1'b1;
				end
			end
			PH_COLLECT: do_collect = 1'b1;
			default:    phase_n = PH_STOP;
		endcase
		if (do_collect) begin
			phase_n = coll_phase;
		end
		if (is_last) begin
			phase_n = PH_TRIM;
		end
	end

	always_comb begin
		tok.rep_one   = rep_one;
		tok.sym_valid = do_collect && (is_digit || is_x);
		tok.sym       = is_x ? isbnn_pkg::X_VALUE : char_byte[3:0];
		tok.last      = is_last;
	end

	// Skipped bytes carry nothing for the checker: drop them here.
	assign tok_push = accept && (tok.rep_one || tok.sym_valid || tok.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TRIM;
		end else if (accept) begin
			phase_q <= phase_n;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/isbnn_queue.sv @@
// ----------------------------------------------------------------------------
// isbnn_queue
// Small token queue between the classifier and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module isbnn_queue #(
	parameter int DEPTH = isbnn_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire isbnn_pkg::tok_t push_tok,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output isbnn_pkg::tok_t      head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	isbnn_pkg::tok_t entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : (wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : (rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/isbnn_back.sv @@
// ----------------------------------------------------------------------------
// isbnn_back
// Checker: stores digits, keeps running check sums and forms the result
// into the output register at the end of each string.
// ----------------------------------------------------------------------------
`default_nettype none

module isbnn_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            tok_valid,
	input  wire isbnn_pkg::tok_t tok,
	output logic                 tok_pop,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output logic [1:0]           status,
	output logic [51:0]          isbn13_bcd
);

	localparam int SD = isbnn_pkg::STORE_DEPTH;

	isbnn_pkg::acc_t acc_q;
	isbnn_pkg::acc_t acc_a;
	isbnn_pkg::acc_t acc_b;
	logic [3:0]      store_q [SD];
	logic [3:0]      store_n [SD];
	logic            out_free;
	logic [1:0]      fin_status;
	logic [51:0]     fin_bcd;
	logic [3:0]      chk10;
	logic [3:0]      chk13;

	assign out_free = !result_valid || !result_stall;
	assign tok_pop  = tok_valid && (!tok.last || out_free);

	// Apply the replayed one first, then the byte's own symbol.
	always_comb begin
		store_n = store_q;
		acc_a   = acc_q;
		if (tok.rep_one) begin
			acc_a = isbnn_pkg::add_sym(acc_q, 4'd1);
			if (acc_q.cnt < 4'(SD)) begin
				store_n[acc_q.cnt] = 4'd1;
			end
		end
		acc_b = acc_a;
		if (tok.sym_valid) begin
			acc_b = isbnn_pkg::add_sym(acc_a, tok.sym);
			if (acc_a.cnt < 4'(SD)) begin
				store_n[acc_a.cnt] = tok.sym;
			end
		end
	end

	assign chk10 = isbnn_pkg::check10(acc_b.c10);
	assign chk13 = isbnn_pkg::check10(acc_b.s10);

	always_comb begin
		fin_bcd    = '0;
		fin_status = isbnn_pkg::ST_BAD_COUNT;
		if (acc_b.cnt == 4'd10) begin
			if (acc_b.x_early || acc_b.s11 != 4'd0) begin
				fin_status = isbnn_pkg::ST_BAD_CHECK;
			end else begin
				fin_status = isbnn_pkg::ST_ISBN10;
				fin_bcd    = {4'd9, 4'd7, 4'd8,
					store_n[0], store_n[1], store_n[2], store_n[3], store_n[4],
					store_n[5], store_n[6], store_n[7], store_n[8], chk10};
			end
		end else if (acc_b.cnt == 4'd13) begin
			if (acc_b.x_any || chk13 != store_n[12]) begin
				fin_status = isbnn_pkg::ST_BAD_CHECK;
			end else begin
				fin_status = isbnn_pkg::ST_ISBN13;
				fin_bcd    = {store_n[0], store_n[1], store_n[2], store_n[3],
					store_n[4], store_n[5], store_n[6], store_n[7], store_n[8],
					store_n[9], store_n[10], store_n[11], store_n[12]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			store_q <= store_n;
		end
		if (tok_pop && tok.last) begin
			status     <= fin_status;
			isbn13_bcd <= fin_bcd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= isbnn_pkg::ACC_CLEAR;
			result_valid <= 1'b0;
		end else begin
			if (tok_pop) begin
				acc_q <= tok.last ? isbnn_pkg::ACC_CLEAR : acc_b;
			end
			if (tok_pop && tok.last) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/isbn_normalizer.sv @@
// ----------------------------------------------------------------------------
// isbn_normalizer
// Streaming ISBN-10 / ISBN-13 validator that emits a status and the
// 13-digit BCD form once per string.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------
//  byte in  | byte_valid / byte_stall    | char_byte[7:0], is_last
//  result   | result_valid / result_stall| status[1:0], isbn13_bcd[51:0]
//
//  One byte is taken per cycle while byte_stall is low; a result leaves after
//  its last byte has passed the queue, then the checker's output register.
//  The classifier feeds a small queue, so it keeps taking bytes while a
//  result waits downstream; only a full queue raises byte_stall.
//  Only the last byte of a string waits for a free output register.
//  Reset clears the classifier phase, queue pointers, check sums and the
//  output valid; the digit store needs no reset.
//
`default_nettype none

module isbn_normalizer #(
	parameter int QUEUE_DEPTH = isbnn_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  char_byte,
	input  wire logic        is_last,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       status,
	output logic [51:0]      isbn13_bcd
);

	// Classified tokens between front and back.
	isbnn_pkg::tok_t push_tok;
	isbnn_pkg::tok_t head_tok;
	logic            push;
	logic            queue_full;
	logic            head_valid;
	logic            pop;

	// Front: trim blanks, strip the prefix, classify each byte.
	isbnn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.char_byte  (char_byte),
		.is_last    (is_last),
		.tok_push   (push),
		.tok        (push_tok),
		.queue_full (queue_full)
	);

	// Hold tokens while the checker waits on its output.
	isbnn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (head_valid),
		.head      (head_tok)
	);

	// Back: accumulate digits and check sums, form one result per string.
	isbnn_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (head_valid),
		.tok          (head_tok),
		.tok_pop      (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.isbn13_bcd   (isbn13_bcd)
	);

endmodule

`default_nettype wire

@@ sim/isbn_normalizer_tb.sv @@
// ----------------------------------------------------------------------------
// isbn_normalizer_tb
// Self-checking bench for the streaming ISBN normalizer. Directed strings cover
// the prefix forms, check digits and stop conditions. A long random run of
// mostly well-formed ISBN strings with noise mixed in follows. Both channels
// idle and stall at random. A local scanner predicts every result, and each
// result transaction is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module isbn_normalizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 1030;
	localparam int IDLE_PCT = 34;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Phases of the front-end scan of one string.
	typedef enum logic [3:0] {
		SCAN_TRIM,
		SCAN_I,
		SCAN_S,
		SCAN_B,
		SCAN_AFTER_WORD,
		SCAN_DASH,
		SCAN_DASH_ONE,
		SCAN_AFTER_NUM,
		SCAN_POST,
		SCAN_DIGITS,
		SCAN_HALT
	} scan_phase_t;

	typedef struct {
		logic [1:0]  status;
		logic [51:0] bcd;
	} isbn_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  char_byte = 8'h00;
	logic        is_last = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  status;
	logic [51:0] isbn13_bcd;

	// Scanner state of the string in flight.
	scan_phase_t phase = SCAN_TRIM;
	int          n_sym = 0;
	int          sym_store[13];
	int          wsum11 = 0;
	int          wsum10 = 0;
	bit          x_in_first9 = 1'b0;
	bit          x_in_first13 = 1'b0;

	isbn_result_t expected_results[$];
	logic [7:0]   pending_text[$];
	int           fail_count = 0;
	int           sent_bytes = 0;
	int           cycle_count = 0;
	bit           calm = 1'b0;

	isbn_normalizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.char_byte    (char_byte),
		.is_last      (is_last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.isbn13_bcd   (isbn13_bcd)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Scanner: follows the block's front end one byte at a time
	// ------------------------------------------------------------------------

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	// Fold one symbol (digit, or X as ten) into the running sums.
	task automatic fold_symbol(input int v);
		if (n_sym < 13) begin
			sym_store[n_sym] = v;
			if (v == isbnn_pkg::X_VALUE) begin
				if (n_sym < 9)
					x_in_first9 = 1'b1;
				x_in_first13 = 1'b1;
			end
			if (n_sym < 10)
				wsum11 = (wsum11 + v * (10 - n_sym)) % 11;
			if (n_sym < 12 && v < 10)
				wsum10 = (wsum10 + v * (n_sym % 2 == 1 ? 3 : 1)) % 10;
		end
		// the count saturates one past a full ISBN-13
		if (n_sym < 14)
			n_sym++;
	endtask

	// Digit collection: keep digits and X, skip hyphen and space, halt on
	// anything else.
	task automatic take_char(input logic [7:0] c);
		phase = SCAN_DIGITS;
		if (c >= "0" && c <= "9")
			fold_symbol(int'(c - "0"));
		else if (c == "x" || c == "X")
			fold_symbol(isbnn_pkg::X_VALUE);
		else if (c != CH_DASH && c != CH_SPACE)
			phase = SCAN_HALT;
	endtask

	function automatic isbn_result_t score_string();
		isbn_result_t r;
		int           s;
		int           v;
		r.status = isbnn_pkg::ST_BAD_COUNT;
		r.bcd = '0;
		if (n_sym == 10) begin
			if (x_in_first9 || wsum11 != 0) begin
				r.status = isbnn_pkg::ST_BAD_CHECK;
			end else begin
				// weighted sum of the 978 prefix
				s = 38;
				r.bcd = 52'h978;
				for (int k = 0; k < 9; k++) begin
					v = sym_store[k] % 10;
					s += v * (k % 2 == 1 ? 1 : 3);
					r.bcd = (r.bcd << 4) | 52'(v);
				end
				r.bcd = (r.bcd << 4) | 52'((10 - s % 10) % 10);
				r.status = isbnn_pkg::ST_ISBN10;
			end
		end else if (n_sym == 13) begin
			if (x_in_first13 || (10 - wsum10) % 10 != sym_store[12]) begin
				r.status = isbnn_pkg::ST_BAD_CHECK;
			end else begin
				for (int k = 0; k < 13; k++)
					r.bcd = (r.bcd << 4) | 52'(sym_store[k] & 15);
				r.status = isbnn_pkg::ST_ISBN13;
			end
		end
		return r;
	endfunction

	task automatic scan_byte(input logic [7:0] c, input logic last);
		logic [7:0] lc;
		lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
		case (phase)
			SCAN_TRIM: begin
				if (!is_blank(c)) begin
					if (lc == "i")
						phase = SCAN_I;
					else
						take_char(c);
				end
			end
			SCAN_I: phase = (lc == "s") ? SCAN_S : SCAN_HALT;
			SCAN_S: phase = (lc == "b") ? SCAN_B : SCAN_HALT;
			SCAN_B: phase = (lc == "n") ? SCAN_AFTER_WORD : SCAN_HALT;
			SCAN_AFTER_WORD: begin
				if (c == CH_DASH)
					phase = SCAN_DASH;
				else if (c == CH_COLON || is_blank(c))
					phase = SCAN_POST;
				else
					take_char(c);
			end
			SCAN_DASH: begin
				if (c == "1")
					phase = SCAN_DASH_ONE;
				else
					take_char(c);
			end
			SCAN_DASH_ONE: begin
				// "-13" / "-10" is a tag; otherwise the held "1" is a digit
				if (c == "3" || c == "0") begin
					phase = SCAN_AFTER_NUM;
				end else begin
					fold_symbol(1);
					take_char(c);
				end
			end
			SCAN_AFTER_NUM: begin
				if (c == CH_COLON || is_blank(c))
					phase = SCAN_POST;
				else
					take_char(c);
			end
			SCAN_POST: begin
				if (!is_blank(c))
					take_char(c);
			end
			SCAN_DIGITS: take_char(c);
			default: phase = SCAN_HALT;
		endcase
		if (last) begin
			expected_results.insert(expected_results.size(), score_string());
			phase = SCAN_TRIM;
			n_sym = 0;
			wsum11 = 0;
			wsum10 = 0;
			x_in_first9 = 1'b0;
			x_in_first13 = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Monitors: check result transactions, then predict from byte transactions
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		isbn_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0d bcd %013h",
							status, isbn13_bcd);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status || isbn13_bcd !== want.bcd) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: status exp %0d got %0d, bcd exp %013h got %013h",
								want.status, status, want.bcd, isbn13_bcd);
					end
				end
			end
			if (byte_valid && !byte_stall)
				scan_byte(char_byte, is_last);
		end
	end

	// Stall the result side at random, except during the calm stretch.
	always @(posedge clk) begin
		if (arst_n)
			result_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL isbn_normalizer");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Byte driver and string builders
	// ------------------------------------------------------------------------

	// Drive one byte and hold it until the block takes it.
	task automatic send_byte(input logic [7:0] c, input logic last);
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				byte_valid <= 1'b0;
				@(posedge clk);
			end
		end
		byte_valid <= 1'b1;
		char_byte <= c;
		is_last <= last;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sent_bytes++;
	endtask

	// Append one byte to the text being built.
	task automatic append_char(input logic [7:0] c);
		pending_text.insert(pending_text.size(), c);
	endtask

	task automatic send_pending();
		for (int i = 0; i < pending_text.size(); i++)
			send_byte(pending_text[i], i == pending_text.size() - 1);
		pending_text.delete();
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			append_char(s[i]);
	endtask

	task automatic send_text(input string s);
		push_str(s);
		send_pending();
	endtask

	// Push a word with each letter in random case.
	task automatic push_word(input string w, input int n);
		logic [7:0] c;
		for (int i = 0; i < n && i < w.len(); i++) begin
			c = w[i];
			if (c >= "a" && c <= "z" && $urandom_range(0, 1))
				c = c - 8'h20;
			append_char(c);
		end
	endtask

	task automatic push_blanks(input int max_n);
		repeat ($urandom_range(0, max_n))
			append_char($urandom_range(0, 2) ? CH_SPACE : CH_TAB);
	endtask

	// Prefix forms: none, the word, word plus tag, word plus a partial tag,
	// or a broken word.
	task automatic push_prefix();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick >= 3 && pick <= 7) begin
			push_word("isbn", 4);
			case (pick)
				4: push_str("-13");
				5: push_str("-10");
				6: push_str("-");
				7: push_str("-1");
				default: ;
			endcase
			if (pick != 7 && $urandom_range(0, 1))
				append_char(CH_COLON);
			if (pick != 7 && $urandom_range(0, 1))
				push_blanks(2);
		end else if (pick == 8) begin
			push_word("isbn", $urandom_range(1, 3));
		end
	endtask

	// Build a valid ISBN-10 or ISBN-13 digit sequence, then maybe break it.
	task automatic push_number();
		int  vals[16];
		int  n;
		int  sum;
		int  pos;
		int  fault;
		bit  is13;
		is13 = $urandom_range(0, 1);
		n = is13 ? 13 : 10;
		sum = 0;
		for (int i = 0; i < n - 1; i++)
			vals[i] = $urandom_range(0, 9);
		if (is13) begin
			if ($urandom_range(0, 4) != 0) begin
				vals[0] = 9;
				vals[1] = 7;
				vals[2] = $urandom_range(8, 9);
			end
			for (int i = 0; i < 12; i++)
				sum += vals[i] * (i % 2 == 1 ? 3 : 1);
			vals[12] = (10 - sum % 10) % 10;
		end else begin
			for (int i = 0; i < 9; i++)
				sum += vals[i] * (10 - i);
			vals[9] = (11 - sum % 11) % 11;
		end
		fault = $urandom_range(0, 99);
		pos = $urandom_range(0, n - 1);
		if (fault < 15) begin
			vals[pos] = (vals[pos] + $urandom_range(1, 9)) % 10;
		end else if (fault < 21) begin
			vals[pos] = isbnn_pkg::X_VALUE;
		end else if (fault < 28) begin
			n = $urandom_range(1, 16);
			for (int i = 0; i < 16; i++)
				if (i >= (is13 ? 13 : 10))
					vals[i] = $urandom_range(0, 9);
		end
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 99) < 15)
				append_char($urandom_range(0, 1) ? CH_DASH : CH_SPACE);
			if (vals[i] == isbnn_pkg::X_VALUE)
				append_char($urandom_range(0, 1) ? "X" : "x");
			else
				append_char(8'("0" + vals[i]));
		end
	endtask

	task automatic push_noise(input int len);
		string pool;
		pool = "0123456789Xx- \t:isbnISBN";
		repeat (len) begin
			if ($urandom_range(0, 1))
				append_char(8'($urandom_range(0, 255)));
			else
				append_char(pool[$urandom_range(0, pool.len() - 1)]);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic test_valid_forms();
		send_text("9780306406157");
		send_text(" \tISBN-13: 978-0-306-40615-7");
		send_text("isbn 0-8044-2957-x");
		send_text("IsBn-10:0306406152");
	endtask

	task automatic test_prefix_cases();
		// held "-1" that turns into a digit
		send_text("isbn-1-86197-271-7");
		// lone hyphen after the word
		send_text("isbn-0306406152");
		// broken word halts at once
		send_text("isb0306406152");
		// colon only counts right after the word or tag
		send_text("978:0306406157");
		send_text("isbn:: 0306406152");
		// tab inside the digits halts collection
		send_text("03064\t06152");
	endtask

	task automatic test_count_and_check();
		send_text("X306406152");
		send_text("9780306406158");
		send_text("978030640615X");
		send_text("12345678901234567");
		append_char(8'h00);
		send_pending();
		append_char(8'hFF);
		send_pending();
	endtask

	task automatic test_random_strings();
		int start_bytes;
		start_bytes = sent_bytes;
		while (sent_bytes - start_bytes < RANDOM_BYTES) begin
			// hold a stretch with no idling on either side
			calm = (sent_bytes - start_bytes > 500) && (sent_bytes - start_bytes < 750);
			if ($urandom_range(0, 99) < 12) begin
				push_noise($urandom_range(1, 12));
			end else begin
				push_blanks(3);
				push_prefix();
				push_number();
				if ($urandom_range(0, 99) < 6) begin
					append_char(CH_TAB);
					push_noise($urandom_range(1, 4));
				end
			end
			send_pending();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_valid_forms();
		test_prefix_cases();
		test_count_and_check();
		test_random_strings();
		byte_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		// keep the clock running to catch stray results
		repeat (10)
			@(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("PASS isbn_normalizer");
		end else begin
			$display("FAIL isbn_normalizer");
		end
		$finish;
	end

endmodule

`default_nettype wire
